FILE: sv/gamepad_input_conditioner_defines.svh
// ----------------------------------------------------------------------------
// gamepad input conditioner assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_INPUT_CONDITIONER_DEFINES_SVH
`define GAMEPAD_INPUT_CONDITIONER_DEFINES_SVH

// checked outside reset
`define GIC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define GIC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/gic_pkg.sv
// ----------------------------------------------------------------------------
// gic_pkg
// types, widths, codes and reset values of the gamepad input conditioner
// ----------------------------------------------------------------------------
package gic_pkg;

   localparam int NUM_BUTTONS_DEF = 21;
   localparam int AXIS_COUNT      = 6;
   localparam int STICK_COUNT     = 4;
   localparam int AXIS_SEL_W      = $clog2(AXIS_COUNT);

   localparam int ACTION_W  = 3;
   localparam int INST_W    = 16;
   localparam int INDEX_W   = 5;
   localparam int AXIS_W    = 16;
   localparam int TRIG_W    = 15;
   localparam int BUTTONS_W = 21;

   localparam int THR_W    = 15;
   localparam int GAIN_W   = 20;
   localparam int PERIOD_W = 16;
   localparam int PROD_W   = THR_W + GAIN_W;
   localparam int ROUND_W  = PROD_W + 1;
   localparam int FRAC_W   = 16;

   localparam int REQ_DATA_W  = 40;
   localparam int REQ_USED_W  = INST_W + INDEX_W + AXIS_W;
   localparam int RSP_USED_W  = 4 * AXIS_W + 2 * TRIG_W + BUTTONS_W;
   localparam int RSP_DATA_W  = 120;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;

   localparam logic [THR_W-1:0]    THR_RESET    = 15'd1638;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 20'd68985;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20;
   localparam logic                STICKY_RESET = 1'b0;

   localparam logic signed [AXIS_W-1:0] AXIS_MOST_NEG = 16'sh8000;
   localparam logic [TRIG_W-1:0]        MAG_MAX       = 15'h7fff;
   localparam logic [ROUND_W-1:0]       ROUND_HALF    = 36'd32768;
   localparam logic [PERIOD_W-1:0]      TICKS_MAX     = 16'hffff;

   typedef enum logic [ACTION_W-1:0] {
      ACT_AXIS     = 3'd0,
      ACT_BTN_DOWN = 3'd1,
      ACT_BTN_UP   = 3'd2,
      ACT_TICK     = 3'd3,
      ACT_ATTACH   = 3'd4,
      ACT_DETACH   = 3'd5
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEADZONE = 2'd0,
      CSR_GAIN     = 2'd1,
      CSR_PERIOD   = 2'd2,
      CSR_STICKY   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0]    threshold;
      logic [GAIN_W-1:0]   gain;
      logic [PERIOD_W-1:0] period;
      logic                sticky;
   } cfg_type;

   typedef struct packed {
      action_type                 action;
      logic [INST_W-1:0]          source_id;
      logic [INDEX_W-1:0]         item_index;
      logic signed [AXIS_W-1:0]   axis_value;
   } req_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] left_x;
      logic signed [AXIS_W-1:0] left_y;
      logic signed [AXIS_W-1:0] right_x;
      logic signed [AXIS_W-1:0] right_y;
      logic [TRIG_W-1:0]        trigger_left;
      logic [TRIG_W-1:0]        trigger_right;
      logic [BUTTONS_W-1:0]     buttons;
   } rsp_type;

endpackage

FILE: sv/gic_csr.sv
// ----------------------------------------------------------------------------
// gic_csr
// configuration registers, written through the plain write port
// ----------------------------------------------------------------------------
module gic_csr
   import gic_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEADZONE: cfg_in.threshold = csr_wdata[THR_W-1:0];
            CSR_GAIN:     cfg_in.gain      = csr_wdata[GAIN_W-1:0];
            CSR_PERIOD:   cfg_in.period    = csr_wdata[PERIOD_W-1:0];
            CSR_STICKY:   cfg_in.sticky    = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THR_RESET;
         cfg_ff.gain      <= GAIN_RESET;
         cfg_ff.period    <= PERIOD_RESET;
         cfg_ff.sticky    <= STICKY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/gic_stick_cond.sv
// ----------------------------------------------------------------------------
// gic_stick_cond
// stick deadzone, q16 gain with rounding, saturation and negation
// ----------------------------------------------------------------------------
module gic_stick_cond
   import gic_pkg::*;
(
   input  logic signed [AXIS_W-1:0] raw,
   input  logic [THR_W-1:0]         threshold,
   input  logic [GAIN_W-1:0]        gain,
   output logic signed [AXIS_W-1:0] value
);

   logic [AXIS_W-1:0]  abs_full;
   logic [THR_W-1:0]   abs_v;
   logic [THR_W-1:0]   mag_adj;
   logic [PROD_W-1:0]  prod;
   logic [ROUND_W-1:0] rounded;
   logic [ROUND_W-FRAC_W-1:0] scaled;
   logic [TRIG_W-1:0]  sat;

   always_comb begin
      abs_full = raw[AXIS_W-1] ? AXIS_W'(-raw) : AXIS_W'(raw);
      // most negative reading folds onto -32767
      abs_v    = (raw == AXIS_MOST_NEG) ? MAG_MAX : abs_full[THR_W-1:0];
      mag_adj  = (abs_v > threshold) ? THR_W'(abs_v - threshold) : '0;
      prod     = PROD_W'(mag_adj) * PROD_W'(gain);
      rounded  = ROUND_W'(prod) + ROUND_HALF;
      scaled   = rounded[ROUND_W-1:FRAC_W];
      sat      = (|scaled[ROUND_W-FRAC_W-1:TRIG_W]) ? MAG_MAX : scaled[TRIG_W-1:0];
      value    = raw[AXIS_W-1] ? $signed({1'b0, sat}) : $signed(AXIS_W'(-{1'b0, sat}));
   end

endmodule

FILE: sv/gic_core.sv
// ----------------------------------------------------------------------------
// gic_core
// binding, axis store, button word, tick counter and publish decision
// ----------------------------------------------------------------------------
module gic_core
   import gic_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    advance,
   input  req_type item,
   output logic    publish,
   output rsp_type result
);

   logic                     connected_ff, connected_in;
   logic [INST_W-1:0]        bound_ff, bound_in;
   logic signed [AXIS_W-1:0] axis_ff [AXIS_COUNT];
   logic signed [AXIS_W-1:0] axis_in [AXIS_COUNT];
   logic [NUM_BUTTONS-1:0]   button_ff, button_in;
   logic                     changed_ff, changed_in;
   logic [PERIOD_W-1:0]      ticks_ff, ticks_in;

   logic signed [AXIS_W-1:0] stick_value;
   logic signed [AXIS_W-1:0] new_value;
   logic [AXIS_SEL_W-1:0]    axis_sel;
   logic                     ours;
   logic                     axis_ok;
   logic                     button_ok;
   logic [NUM_BUTTONS-1:0]   button_mask;
   logic                     button_cur;
   logic                     press;
   logic [PERIOD_W-1:0]      ticks_next;
   logic [BUTTONS_W+NUM_BUTTONS-1:0] button_pad;

   gic_stick_cond u_stick_cond (
      .raw       (item.axis_value),
      .threshold (cfg.threshold),
      .gain      (cfg.gain),
      .value     (stick_value)
   );

   always_comb begin
      axis_sel    = item.item_index[AXIS_SEL_W-1:0];
      ours        = connected_ff && (item.source_id == bound_ff);
      axis_ok     = item.item_index < INDEX_W'(AXIS_COUNT);
      button_ok   = {1'b0, item.item_index} < (INDEX_W + 1)'(NUM_BUTTONS);
      button_mask = NUM_BUTTONS'(1) << item.item_index;
      button_cur  = |(button_ff & button_mask);
      press       = item.action == ACT_BTN_DOWN;
      ticks_next  = (ticks_ff == TICKS_MAX) ? ticks_ff : PERIOD_W'(ticks_ff + 1'b1);
      if (item.item_index < INDEX_W'(STICK_COUNT)) begin
         new_value = stick_value;
      end else begin
         new_value = item.axis_value[AXIS_W-1] ? '0 : item.axis_value;
      end

      connected_in = connected_ff;
      bound_in     = bound_ff;
      axis_in      = axis_ff;
      button_in    = button_ff;
      changed_in   = changed_ff;
      ticks_in     = ticks_ff;
      publish      = 1'b0;

      if (advance) begin
         unique case (item.action) inside
            ACT_AXIS: begin
               if (ours && axis_ok && (axis_ff[axis_sel] != new_value)) begin
                  axis_in[axis_sel] = new_value;
                  changed_in        = 1'b1;
               end
            end
            ACT_BTN_DOWN, ACT_BTN_UP: begin
               if (ours && button_ok) begin
                  if (cfg.sticky ? press : (button_cur != press)) begin
                     button_in  = button_ff ^ button_mask;
                     changed_in = 1'b1;
                  end
               end
            end
            ACT_TICK: begin
               if (connected_ff) begin
                  if (changed_ff || ((cfg.period != '0) && (ticks_next >= cfg.period))) begin
                     publish    = 1'b1;
                     changed_in = 1'b0;
                     ticks_in   = '0;
                  end else begin
                     ticks_in = ticks_next;
                  end
               end
            end
            ACT_ATTACH: begin
               if (!connected_ff) begin
                  connected_in = 1'b1;
                  bound_in     = item.source_id;
                  axis_in      = '{default: '0};
                  button_in    = '0;
                  changed_in   = 1'b0;
                  ticks_in     = '0;
                  publish      = 1'b1;
               end
            end
            ACT_DETACH: begin
               if (ours) begin
                  connected_in = 1'b0;
                  bound_in     = '0;
                  axis_in      = '{default: '0};
                  button_in    = '0;
                  changed_in   = 1'b0;
                  ticks_in     = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // attach publishes the cleared state
   always_comb begin
      button_pad = {{BUTTONS_W{1'b0}}, button_ff};
      if (item.action == ACT_ATTACH) begin
         result = '0;
      end else begin
         result.left_x        = axis_ff[0];
         result.left_y        = axis_ff[1];
         result.right_x       = axis_ff[2];
         result.right_y       = axis_ff[3];
         result.trigger_left  = axis_ff[4][TRIG_W-1:0];
         result.trigger_right = axis_ff[5][TRIG_W-1:0];
         result.buttons       = button_pad[BUTTONS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff <= 1'b0;
         bound_ff     <= '0;
         axis_ff      <= '{default: '0};
         button_ff    <= '0;
         changed_ff   <= 1'b0;
         ticks_ff     <= '0;
      end else begin
         connected_ff <= connected_in;
         bound_ff     <= bound_in;
         axis_ff      <= axis_in;
         button_ff    <= button_in;
         changed_ff   <= changed_in;
         ticks_ff     <= ticks_in;
      end
   end

endmodule

FILE: sv/gamepad_input_conditioner.sv
// pipeline: a request is registered at acceptance and its result, if any, is
// registered as the request advances, which waits while a result is stalled
// throughput: one request per cycle without a stall, set by the state update loop
// reset: synchronous, active high; clears binding, axes, buttons, tick count and
// both pipeline valid flags, and loads the configuration reset values
// ----------------------------------------------------------------------------
// gamepad_input_conditioner
// conditions gamepad events and publishes the controller state
// ----------------------------------------------------------------------------
module gamepad_input_conditioner
   import gic_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // source_id[15:0], item_index[20:16], axis_value[36:21], zero fill
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // action[2:0]
   input  logic [ACTION_W-1:0]    req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // left_x, left_y, right_x, right_y, trigger_left, trigger_right, buttons, zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,

   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type req_item;
   req_type s1_req_ff;
   logic    s1_valid_ff, s1_valid_in;
   logic    advance;
   logic    publish;
   rsp_type result;
   logic    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   gic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   always_comb begin
      req_item.action      = action_type'(req_tuser);
      req_item.source_id   = req_tdata[INST_W-1:0];
      req_item.item_index  = req_tdata[INST_W+INDEX_W-1:INST_W];
      req_item.axis_value  = $signed(req_tdata[REQ_USED_W-1:INST_W+INDEX_W]);
   end

   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_req_ff <= req_item;
      end
   end

   gic_core #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (s1_req_ff),
      .publish (publish),
      .result  (result)
   );

   assign rsp_valid_in = publish || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (publish) begin
         rsp_data_ff <= {{(RSP_DATA_W-RSP_USED_W){1'b0}},
                         result.buttons, result.trigger_right, result.trigger_left,
                         result.right_y, result.right_x, result.left_y, result.left_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sv/gic_checker.sv
// ----------------------------------------------------------------------------
// gic_checker
// port-level checks of the gamepad input conditioner, bound to the top level
// ----------------------------------------------------------------------------
`include "gamepad_input_conditioner_defines.svh"

module gic_checker
   import gic_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // no result is pending right after reset
   `GIC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // requests stall only behind a result that is not taken
   `GIC_ASSERT(a_stall_cause, clock, reset, !req_tready |-> (rsp_tvalid && !rsp_tready),
      "request stalled without output back-pressure")

   // a stalled result holds
   `GIC_ASSERT(a_rsp_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)),
      "stalled result changed")

   // conditioned sticks never reach the most negative code
   `GIC_ASSERT(a_stick_range, clock, reset,
      rsp_tvalid |-> ((rsp_tdata[15:0] != AXIS_MOST_NEG) && (rsp_tdata[31:16] != AXIS_MOST_NEG) &&
      (rsp_tdata[47:32] != AXIS_MOST_NEG) && (rsp_tdata[63:48] != AXIS_MOST_NEG)),
      "stick value out of range")

endmodule

bind gamepad_input_conditioner gic_checker u_checker (.*);
